// File: sv/kbm_pkg.sv
// ----------------------------------------------------------------------------
// kbm_pkg
// Shared widths, register indexes, sequencer states and result type of the
// ranked path merge block.
// ----------------------------------------------------------------------------
package kbm_pkg;

  localparam int NUM_RATES  = 4;
  localparam int RATE_W     = 32;
  localparam int FAC_W      = 64;
  localparam int MONTH_W    = 13;
  localparam int RANK_W     = 4;
  localparam int TERM_W     = 7;
  localparam int TCNT_W     = 3;
  localparam int RANKS_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam int DEF_MAX_TERMS    = 4;
  localparam int DEF_MAX_TERM_LEN = 64;
  localparam int DEF_MAX_RANKS    = 16;
  localparam int DEF_MAX_MONTHS   = 4096;

  localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_LEN_A   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_LEN_B   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_LEN_C   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_LEN_D   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RANKS_WANTED = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_WRATE,
    S_HINIT,
    S_RATE,
    S_LOAD,
    S_FDATA,
    S_MHI,
    S_MCOMB,
    S_SCAN,
    S_PICK,
    S_FLUSH
  } st_t;

  typedef struct packed {
    logic [MONTH_W-1:0] month_no;
    logic [RANK_W-1:0]  rank_no;
    logic [FAC_W-1:0]   factor_total;
    logic [TERM_W-1:0]  term_taken;
    logic [RANK_W-1:0]  from_rank;
    logic               overflowed;
  } res_t;

endpackage

// File: sv/kbm_if.sv
// ----------------------------------------------------------------------------
// kbm_if
// Valid/ready channel interfaces for rates in, ranked entries out and
// register writes.
// ----------------------------------------------------------------------------
interface kbm_in_if import kbm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [RATE_W-1:0] rate_a;
  logic signed [RATE_W-1:0] rate_b;
  logic signed [RATE_W-1:0] rate_c;
  logic signed [RATE_W-1:0] rate_d;
  logic                     first_month;
  modport source (output valid, rate_a, rate_b, rate_c, rate_d, first_month, input ready);
  modport sink (input valid, rate_a, rate_b, rate_c, rate_d, first_month, output ready);
endinterface

interface kbm_out_if import kbm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MONTH_W-1:0] month_no;
  logic [RANK_W-1:0]  rank_no;
  logic [FAC_W-1:0]   factor_total;
  logic [TERM_W-1:0]  term_taken;
  logic [RANK_W-1:0]  from_rank;
  logic               overflowed;
  logic               row_end;
  modport source (output valid, month_no, rank_no, factor_total, term_taken, from_rank,
                  overflowed, row_end, input ready);
  modport sink (input valid, month_no, rank_no, factor_total, term_taken, from_rank,
                overflowed, row_end, output ready);
endinterface

interface kbm_cfg_if import kbm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/kbm_ram.sv
// ----------------------------------------------------------------------------
// kbm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module kbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// File: sv/kbm_mul.sv
// ----------------------------------------------------------------------------
// kbm_mul
// Shared 32 by 32 multiplier with registered product, and the saturating
// recombination of the low and high partial products of a Q32.32 value
// times a Q2.30 factor.
// ----------------------------------------------------------------------------
module kbm_mul import kbm_pkg::*; (
  input  logic             clk,
  input  logic [31:0]      op_a,
  input  logic [31:0]      op_b,
  input  logic             hold_lo,
  output logic [FAC_W-1:0] sat_val,
  output logic             sat_ovf
);

  logic [63:0] prod_r;
  logic [63:0] lo_r;
  logic [64:0] sum;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (hold_lo) begin
      lo_r <= prod_r;
    end
  end

  assign sum = {1'b0, prod_r[61:0], 2'b00} + {31'd0, lo_r[63:30]};

  always_comb begin
    if (prod_r[63:62] != 2'b00 || sum[64]) begin
      sat_val = '1;
      sat_ovf = 1'b1;
    end else begin
      sat_val = sum[63:0];
      sat_ovf = 1'b0;
    end
  end

endmodule

// File: sv/k_best_path_merge_dp.sv
// ----------------------------------------------------------------------------
// k_best_path_merge_dp
// Ranked best-sequence builder for term investments by a k-way merge.
// ----------------------------------------------------------------------------
// One transaction on in_ch carries the rates of every term starting in one
// month. The block then builds the ranked row of the next month and sends
// its entries on out_ch, best rank first, with row_end on the last one.
// Registers must be written on cfg_ch, which is always ready, only while idle;
// the user is bound by this, the block itself does not enforce it. in_ch is
// ready only while no month is in progress. Each month starts, then loads the
// waiting head and the head of each term source, then per emitted rank runs
// the compare scan over every source, picks, and reloads the winning head,
// and finishes. An item that starts no month goes straight back to idle. The
// single shared multiplier, the single compare scan and the one read port of
// the row memory serialize these steps.
// The last entry is held back one step so that row_end is known; when out_ch
// stalls, the sequencer waits with the pending entry.
// Reset clears the month state and the row fill counts; an item without
// first_month before the first restart causes no transaction.
// ----------------------------------------------------------------------------
module k_best_path_merge_dp import kbm_pkg::*; #(
  parameter int MAX_TERMS    = DEF_MAX_TERMS,
  parameter int MAX_TERM_LEN = DEF_MAX_TERM_LEN,
  parameter int MAX_RANKS    = DEF_MAX_RANKS,
  parameter int MAX_MONTHS   = DEF_MAX_MONTHS
) (
  input logic       clk,
  input logic       rst_n,
  kbm_in_if.sink    in_ch,
  kbm_out_if.source out_ch,
  kbm_cfg_if.sink   cfg_ch
);

  localparam int ACT       = (MAX_TERMS < NUM_RATES) ? MAX_TERMS : NUM_RATES;
  localparam int NSRC      = ACT + 1;
  localparam int HW        = $clog2(NSRC);
  localparam int ROW_SLOTS = MAX_TERM_LEN + 1;
  localparam int SW        = $clog2(ROW_SLOTS);
  localparam int TW        = $clog2(MAX_TERM_LEN);
  localparam int RW        = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
  localparam int KW        = $clog2(MAX_RANKS + 1);
  localparam int MW        = $clog2(MAX_MONTHS + 1);
  localparam int FDEPTH    = ROW_SLOTS * MAX_RANKS;
  localparam int FAW       = $clog2(FDEPTH);

  st_t st_r, st_nxt;

  logic [TCNT_W-1:0]  tcnt_cfg_r;
  logic [TERM_W-1:0]  len_r [NUM_RATES];
  logic [RANKS_W-1:0] ranks_cfg_r;

  logic [RATE_W-1:0] rin_r [NUM_RATES];
  logic              first_r;
  logic              started_r;
  logic [MW-1:0]     month_r;
  logic [SW-1:0]     wp_r;
  logic [TW-1:0]     rp_r;
  logic [KW-1:0]     fill_r [ROW_SLOTS];

  logic             live_r [NSRC];
  logic [FAC_W-1:0] val_r [NSRC];
  logic             hovf_r [NSRC];
  logic [RW-1:0]    rank_r [NSRC];
  logic [SW-1:0]    slot_r [NSRC];
  logic [31:0]      fac_r [NSRC];

  logic [HW-1:0]     j_r;
  logic              reload_r;
  logic [KW-1:0]     n_r;
  logic [KW-1:0]     k_r;
  logic [TCNT_W-1:0] tc_r;
  logic [31:0]       fhi_r;
  logic              fovf_r;

  logic              found_r;
  logic [HW-1:0]     best_r;
  logic [FAC_W-1:0]  bval_r;
  logic              bovf_r;
  logic [RW-1:0]     brank_r;
  logic [TERM_W-1:0] bterm_r;

  res_t pend_r;
  logic pend_v_r;
  res_t out_r;
  logic out_end_r;
  logic out_valid_r;

  logic [MW:0]           m_w;
  logic [SW-1:0]         dst_w;
  logic [TERM_W-1:0]     len_j;
  logic [RATE_W-1:0]     lane_j;
  logic                  hv_j;
  logic [SW+1:0]         slot_t;
  logic [SW-1:0]         slot_calc;
  logic [TW+1:0]         ridx_t;
  logic [TW-1:0]         ridx_calc;
  logic signed [33:0]    fsum;
  logic [31:0]           fac_calc;
  logic                  live_j;
  logic                  start_ok;
  logic                  last_src;
  logic                  adv;
  logic                  row_done;
  logic                  more_rank;
  logic [KW-1:0]         k_calc;
  logic [TCNT_W-1:0]     tc_calc;
  res_t                  new_res;

  logic                  r_we;
  logic [TW-1:0]         r_raddr;
  logic [ACT*RATE_W-1:0] r_wdata;
  logic [ACT*RATE_W-1:0] r_rdata;
  logic                  f_we;
  logic [FAW-1:0]        f_waddr;
  logic [FAC_W:0]        f_wdata;
  logic [FAW-1:0]        f_raddr;
  logic [FAC_W:0]        f_rdata;
  logic [31:0]           mul_a;
  logic                  mul_hold;
  logic [FAC_W-1:0]      sat_val;
  logic                  sat_ovf;
  logic                  out_ld;
  logic                  out_ld_end;

  kbm_ram #(.WIDTH(ACT * RATE_W), .DEPTH(MAX_TERM_LEN)) u_rate_ram (
    .clk     (clk),
    .we      (r_we),
    .waddr   (rp_r),
    .wdata   (r_wdata),
    .raddr   (r_raddr),
    .rdata_r (r_rdata)
  );

  kbm_ram #(.WIDTH(FAC_W + 1), .DEPTH(FDEPTH)) u_row_ram (
    .clk     (clk),
    .we      (f_we),
    .waddr   (f_waddr),
    .wdata   (f_wdata),
    .raddr   (f_raddr),
    .rdata_r (f_rdata)
  );

  kbm_mul u_mul (
    .clk     (clk),
    .op_a    (mul_a),
    .op_b    (fac_r[j_r]),
    .hold_lo (mul_hold),
    .sat_val (sat_val),
    .sat_ovf (sat_ovf)
  );

  assign in_ch.ready  = (st_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.month_no     = out_r.month_no;
  assign out_ch.rank_no      = out_r.rank_no;
  assign out_ch.factor_total = out_r.factor_total;
  assign out_ch.term_taken   = out_r.term_taken;
  assign out_ch.from_rank    = out_r.from_rank;
  assign out_ch.overflowed   = out_r.overflowed;
  assign out_ch.row_end      = out_end_r;

  always_comb begin
    m_w   = {1'b0, month_r} + (MW+1)'(1);
    dst_w = (wp_r == SW'(ROW_SLOTS - 1)) ? '0 : wp_r + SW'(1);
    len_j  = '0;
    lane_j = '0;
    for (int l = 0; l < ACT; l++) begin
      if (j_r == HW'(l + 1)) begin
        len_j  = len_r[l];
        lane_j = r_rdata[l*RATE_W +: RATE_W];
      end
    end
    hv_j = (len_j != '0) && (16'(len_j) <= 16'(MAX_TERM_LEN)) &&
           ((MW+1)'(len_j) <= m_w) && (8'(j_r) <= 8'(tc_r));
    slot_t = (SW+2)'(wp_r) + (SW+2)'(ROW_SLOTS + 1) - (SW+2)'(len_j);
    if (slot_t >= (SW+2)'(ROW_SLOTS)) begin
      slot_t = slot_t - (SW+2)'(ROW_SLOTS);
    end
    slot_calc = slot_t[SW-1:0];
    ridx_t = (TW+2)'(rp_r) + (TW+2)'(MAX_TERM_LEN + 1) - (TW+2)'(len_j);
    if (ridx_t >= (TW+2)'(MAX_TERM_LEN)) begin
      ridx_t = ridx_t - (TW+2)'(MAX_TERM_LEN);
    end
    ridx_calc = ridx_t[TW-1:0];
    fsum      = 34'sh4000_0000 + 34'($signed(lane_j));
    fac_calc  = fsum[33] ? 32'd0 : fsum[31:0];
    live_j    = (KW'(rank_r[j_r]) < fill_r[slot_r[j_r]]);
    start_ok  = started_r && ((MW+1)'(month_r) + (MW+1)'(1) < (MW+1)'(MAX_MONTHS));
    last_src  = (j_r == HW'(NSRC - 1));
    adv       = !pend_v_r || !out_valid_r || out_ch.ready;
    row_done  = (n_r + KW'(1) == k_r);
    more_rank = ((KW+1)'(brank_r) + (KW+1)'(1) < (KW+1)'(k_r));
    if (ranks_cfg_r == '0) begin
      k_calc = KW'(1);
    end else if (32'(ranks_cfg_r) > MAX_RANKS) begin
      k_calc = KW'(MAX_RANKS);
    end else begin
      k_calc = KW'(ranks_cfg_r);
    end
    tc_calc = (32'(tcnt_cfg_r) > ACT) ? TCNT_W'(ACT) : tcnt_cfg_r;
    new_res.month_no     = MONTH_W'(m_w);
    new_res.rank_no      = RANK_W'(n_r);
    new_res.factor_total = bval_r;
    new_res.term_taken   = bterm_r;
    new_res.from_rank    = RANK_W'(brank_r);
    new_res.overflowed   = bovf_r;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          st_nxt = S_START;
        end
      end
      S_START: begin
        st_nxt = (first_r || start_ok) ? S_WRATE : S_IDLE;
      end
      S_WRATE: st_nxt = S_HINIT;
      S_HINIT: begin
        if (j_r == '0) begin
          st_nxt = S_LOAD;
        end else if (hv_j) begin
          st_nxt = S_RATE;
        end else begin
          st_nxt = last_src ? S_SCAN : S_HINIT;
        end
      end
      S_RATE: st_nxt = S_LOAD;
      S_LOAD: begin
        if (live_j) begin
          st_nxt = S_FDATA;
        end else if (reload_r || last_src) begin
          st_nxt = S_SCAN;
        end else begin
          st_nxt = S_HINIT;
        end
      end
      S_FDATA: begin
        if (j_r != '0) begin
          st_nxt = S_MHI;
        end else begin
          st_nxt = (reload_r || last_src) ? S_SCAN : S_HINIT;
        end
      end
      S_MHI: st_nxt = S_MCOMB;
      S_MCOMB: st_nxt = (reload_r || last_src) ? S_SCAN : S_HINIT;
      S_SCAN: begin
        if (last_src) begin
          st_nxt = S_PICK;
        end
      end
      S_PICK: begin
        if (!found_r) begin
          st_nxt = S_FLUSH;
        end else if (adv) begin
          if (row_done) begin
            st_nxt = S_FLUSH;
          end else if (more_rank) begin
            st_nxt = S_LOAD;
          end else begin
            st_nxt = S_SCAN;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v_r || !out_valid_r || out_ch.ready) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    r_we     = (st_r == S_WRATE);
    r_raddr  = ridx_calc;
    for (int l = 0; l < ACT; l++) begin
      r_wdata[l*RATE_W +: RATE_W] = rin_r[l];
    end
    f_we     = 1'b0;
    f_waddr  = FAW'(dst_w) * FAW'(MAX_RANKS) + FAW'(n_r);
    f_wdata  = {bovf_r, bval_r};
    f_raddr  = FAW'(slot_r[j_r]) * FAW'(MAX_RANKS) + FAW'(rank_r[j_r]);
    mul_a    = (st_r == S_FDATA) ? f_rdata[31:0] : fhi_r;
    mul_hold = (st_r == S_MHI);
    out_ld     = 1'b0;
    out_ld_end = 1'b0;
    unique case (st_r)
      S_START: begin
        if (first_r) begin
          f_we    = 1'b1;
          f_waddr = '0;
          f_wdata = {1'b0, 64'h0000_0001_0000_0000};
        end
      end
      S_PICK: begin
        if (found_r && adv) begin
          f_we   = 1'b1;
          out_ld = pend_v_r;
        end
      end
      S_FLUSH: begin
        if (pend_v_r && (!out_valid_r || out_ch.ready)) begin
          out_ld     = 1'b1;
          out_ld_end = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      tcnt_cfg_r  <= TCNT_W'(1);
      len_r[0]    <= TERM_W'(1);
      len_r[1]    <= TERM_W'(2);
      len_r[2]    <= TERM_W'(3);
      len_r[3]    <= TERM_W'(4);
      ranks_cfg_r <= RANKS_W'(1);
      started_r   <= 1'b0;
      month_r     <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      for (int s = 0; s < ROW_SLOTS; s++) begin
        fill_r[s] <= '0;
      end
      for (int h = 0; h < NSRC; h++) begin
        live_r[h] <= 1'b0;
      end
    end else begin
      st_r <= st_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_TERM_COUNT:   tcnt_cfg_r  <= cfg_ch.data[TCNT_W-1:0];
          CFG_TERM_LEN_A:   len_r[0]    <= cfg_ch.data;
          CFG_TERM_LEN_B:   len_r[1]    <= cfg_ch.data;
          CFG_TERM_LEN_C:   len_r[2]    <= cfg_ch.data;
          CFG_TERM_LEN_D:   len_r[3]    <= cfg_ch.data;
          CFG_RANKS_WANTED: ranks_cfg_r <= cfg_ch.data[RANKS_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (out_ld) begin
        out_r       <= pend_r;
        out_end_r   <= out_ld_end;
        out_valid_r <= 1'b1;
      end
      unique case (st_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            rin_r[0] <= in_ch.rate_a;
            rin_r[1] <= in_ch.rate_b;
            rin_r[2] <= in_ch.rate_c;
            rin_r[3] <= in_ch.rate_d;
            first_r  <= in_ch.first_month;
          end
        end
        S_START: begin
          if (first_r) begin
            started_r <= 1'b1;
            month_r   <= '0;
            wp_r      <= '0;
            rp_r      <= '0;
            for (int s = 0; s < ROW_SLOTS; s++) begin
              fill_r[s] <= (s == 0) ? KW'(1) : '0;
            end
          end else if (start_ok) begin
            month_r <= month_r + MW'(1);
            wp_r    <= (wp_r == SW'(ROW_SLOTS - 1)) ? '0 : wp_r + SW'(1);
            rp_r    <= (rp_r == TW'(MAX_TERM_LEN - 1)) ? '0 : rp_r + TW'(1);
          end
        end
        S_WRATE: begin
          fill_r[dst_w] <= '0;
          k_r      <= k_calc;
          tc_r     <= tc_calc;
          j_r      <= '0;
          n_r      <= '0;
          reload_r <= 1'b0;
          pend_v_r <= 1'b0;
        end
        S_HINIT: begin
          if (j_r == '0) begin
            slot_r[0] <= wp_r;
            rank_r[0] <= '0;
          end else if (hv_j) begin
            slot_r[j_r] <= slot_calc;
            rank_r[j_r] <= '0;
          end else begin
            live_r[j_r] <= 1'b0;
            j_r         <= last_src ? '0 : j_r + HW'(1);
            found_r     <= 1'b0;
          end
        end
        S_RATE: fac_r[j_r] <= fac_calc;
        S_LOAD: begin
          if (!live_j) begin
            live_r[j_r] <= 1'b0;
            j_r         <= (reload_r || last_src) ? '0 : j_r + HW'(1);
            found_r     <= 1'b0;
          end
        end
        S_FDATA: begin
          if (j_r != '0) begin
            fhi_r  <= f_rdata[63:32];
            fovf_r <= f_rdata[FAC_W];
          end else begin
            val_r[0]  <= f_rdata[FAC_W-1:0];
            hovf_r[0] <= f_rdata[FAC_W];
            live_r[0] <= 1'b1;
            j_r       <= (reload_r || last_src) ? '0 : j_r + HW'(1);
            found_r   <= 1'b0;
          end
        end
        S_MHI: begin
        end
        S_MCOMB: begin
          val_r[j_r]  <= sat_val;
          hovf_r[j_r] <= fovf_r | sat_ovf;
          live_r[j_r] <= 1'b1;
          j_r         <= (reload_r || last_src) ? '0 : j_r + HW'(1);
          found_r     <= 1'b0;
        end
        S_SCAN: begin
          if (live_r[j_r] && (!found_r || val_r[j_r] > bval_r)) begin
            found_r <= 1'b1;
            best_r  <= j_r;
            bval_r  <= val_r[j_r];
            bovf_r  <= hovf_r[j_r];
            brank_r <= rank_r[j_r];
            bterm_r <= (j_r == '0) ? '0 : len_j;
          end
          if (!last_src) begin
            j_r <= j_r + HW'(1);
          end
        end
        S_PICK: begin
          if (found_r && adv) begin
            fill_r[dst_w] <= n_r + KW'(1);
            pend_r        <= new_res;
            pend_v_r      <= 1'b1;
            n_r           <= n_r + KW'(1);
            reload_r      <= 1'b1;
            found_r       <= 1'b0;
            if (more_rank) begin
              rank_r[best_r] <= brank_r + RW'(1);
              j_r            <= best_r;
            end else begin
              live_r[best_r] <= 1'b0;
              j_r            <= '0;
            end
          end
        end
        S_FLUSH: begin
          if (out_ld) begin
            pend_v_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while a month was in progress");

  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_PICK && found_r) |-> (n_r < k_r))
    else $error("more ranks picked than wanted");

  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MCOMB) |-> ($past(st_r) == S_MHI))
    else $error("product combined without both partial products");

  a_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> !pend_v_r)
    else $error("pending entry left behind at end of row");
`endif

endmodule
